// ===== rtl/core/triangle_frustum_clipper_macros.svh =====
// Assertion macros used by the clipper sequencer.
`ifndef TRIANGLE_FRUSTUM_CLIPPER_MACROS_SVH
`define TRIANGLE_FRUSTUM_CLIPPER_MACROS_SVH
// Same-cycle implication, checked out of reset.
`define TFC_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define TFC_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/tfc_pkg.sv =====
// Types, constants and plane distance function for the frustum clipper.
package tfc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_FIELDS  = 7;
   localparam int DIST_WIDTH  = COORD_WIDTH + 1;
   localparam int DEN_WIDTH   = COORD_WIDTH + 2;
   localparam int T_WIDTH     = FRAC_BITS + 1;

   localparam logic [2:0] PLANE_NEAR   = 3'd0;
   localparam logic [2:0] PLANE_FAR    = 3'd1;
   localparam logic [2:0] PLANE_LEFT   = 3'd2;
   localparam logic [2:0] PLANE_TOP    = 3'd3;
   localparam logic [2:0] PLANE_RIGHT  = 3'd4;
   localparam logic [2:0] PLANE_BOTTOM = 3'd5;
   localparam logic [2:0] PLANE_COUNT  = 3'd6;

   localparam logic [2:0] FIELD_X    = 3'd0;
   localparam logic [2:0] FIELD_Y    = 3'd1;
   localparam logic [2:0] FIELD_Z    = 3'd2;
   localparam logic [2:0] FIELD_W    = 3'd3;
   localparam logic [2:0] FIELD_A    = 3'd4;
   localparam logic [2:0] FIELD_B    = 3'd5;
   localparam logic [2:0] FIELD_C    = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic signed [COORD_WIDTH-1:0] pos_w;
      logic signed [COORD_WIDTH-1:0] attr_a;
      logic signed [COORD_WIDTH-1:0] attr_b;
      logic signed [COORD_WIDTH-1:0] attr_c;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic signed [COORD_WIDTH-1:0] out_w;
      logic signed [COORD_WIDTH-1:0] out_attr_a;
      logic signed [COORD_WIDTH-1:0] out_attr_b;
      logic signed [COORD_WIDTH-1:0] out_attr_c;
      logic                          last_vertex;
      logic                          empty_polygon;
   } rsp_word_type;

   typedef logic [NUM_FIELDS-1:0][COORD_WIDTH-1:0] vertex_type;

   typedef struct packed {
      logic       rd;
      logic       wr_in;
      logic       wr_cross;
      logic       wr_cur;
      logic       ld_last;
      logic       ld_cur;
      logic       shift_last;
      logic       div_start;
      logic       div_step;
      logic       lerp_mul;
      logic       lerp_add;
      logic [2:0] fld;
      logic [2:0] plane;
      logic       rsp_load;
      logic       rsp_last;
      logic       rsp_empty;
   } cmd_type;

   typedef struct packed {
      logic inside_cur;
      logic inside_last;
      logic rsp_free;
   } sts_type;

   function automatic logic signed [DIST_WIDTH-1:0] plane_dist(input logic [2:0] p,
                                                              input vertex_type v);
      logic signed [DIST_WIDTH-1:0] x, y, z, w, d;
      x = DIST_WIDTH'($signed(v[FIELD_X]));
      y = DIST_WIDTH'($signed(v[FIELD_Y]));
      z = DIST_WIDTH'($signed(v[FIELD_Z]));
      w = DIST_WIDTH'($signed(v[FIELD_W]));
      case (p)
         PLANE_NEAR:   d = w + z;
         PLANE_FAR:    d = w - z;
         PLANE_LEFT:   d = w + x;
         PLANE_TOP:    d = w + y;
         PLANE_RIGHT:  d = w - x;
         PLANE_BOTTOM: d = w - y;
         default:      d = w;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/triangle_frustum_clipper.sv =====
// Top level of the homogeneous frustum triangle clipper.
// The first and second vertex words of a triangle are stored; the third starts clipping. Per plane
// the last vertex is read, then each polygon vertex is read, loaded and tested; each crossing runs
// the divider, interpolates every field and writes the new vertex. Then the result words go out.
// One triangle is in work at a time and the input stalls meanwhile; the divider sets the pace.
// Reset (synchronous, active high) clears the sequencer, vertex count and result valid.
module triangle_frustum_clipper #(
   parameter int MAX_POLY_VERTS = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tfc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tfc_pkg::rsp_word_type rsp_data
);

   // The polygon memory holds two banks of MAX_POLY_VERTS vertices; clipping
   // against one plane reads one bank and writes the other.
   localparam int AW = $clog2(2 * MAX_POLY_VERTS);
   // Counters must hold the full bank size itself.
   localparam int CW = $clog2(MAX_POLY_VERTS + 1);

   tfc_pkg::cmd_type cmd;
   tfc_pkg::sts_type sts;
   logic [AW-1:0]    raddr;
   logic [AW-1:0]    waddr;

   // The controller walks planes, then vertices of the source bank, and for each
   // edge that crosses the plane runs the divider and the field interpolator.
   tfc_ctrl #(
      .MAX_POLY_VERTS (MAX_POLY_VERTS),
      .AW             (AW),
      .CW             (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .raddr     (raddr),
      .waddr     (waddr)
   );

   // The datapath owns the memory, the distance logic, the divider, the
   // interpolator and the result word register that decouples the output side.
   tfc_dpath #(
      .MAX_POLY_VERTS (MAX_POLY_VERTS),
      .AW             (AW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .raddr     (raddr),
      .waddr     (waddr),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/tfc_dpath.sv =====
// Datapath of the clipper: polygon memory, distances, divider, interpolator, result register.
module tfc_dpath #(
   parameter int MAX_POLY_VERTS = 9,
   parameter int AW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tfc_pkg::cmd_type      cmd,
   input  logic [AW-1:0]         raddr,
   input  logic [AW-1:0]         waddr,
   input  tfc_pkg::req_word_type req_data,
   output tfc_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tfc_pkg::rsp_word_type rsp_data
);

   localparam int W  = tfc_pkg::COORD_WIDTH;
   localparam int F  = tfc_pkg::FRAC_BITS;
   localparam int DW = tfc_pkg::DIST_WIDTH;
   localparam int NW = tfc_pkg::DEN_WIDTH;
   localparam int TW = tfc_pkg::T_WIDTH;
   localparam int HW = W + 1 - F;
   localparam int PW = HW + TW;
   localparam int SW = W + 4;
   localparam int DEPTH = 2 * MAX_POLY_VERTS;

   tfc_pkg::vertex_type mem [DEPTH];
   tfc_pkg::vertex_type rd_ff, cur_ff, last_ff, cross_ff, in_vert, wdata;
   logic signed [DW-1:0] dc_ff, dl_ff, rd_dist;
   logic [DW-1:0] abs_c, abs_l;
   logic [NW-1:0] den_ff, rem_ff, den_in, rem_in, rem_sh_sub;
   logic [NW:0]   rem_sh;
   logic [TW-1:0] t_ff;
   logic          first_ge, step_ge;
   logic signed [W:0] diff;
   logic [W:0]    mag;
   logic [PW-1:0] phi_ff;
   logic [TW-1:0] plo_ff;
   logic          neg_ff;
   logic [F+TW-1:0] lo_prod;
   logic [PW:0]   prod;
   logic signed [SW-1:0] sum;
   logic [W-1:0]  sat_val;
   logic          rsp_valid_ff;
   tfc_pkg::rsp_word_type rsp_ff;

   always_comb begin
      in_vert = '0;
      in_vert[tfc_pkg::FIELD_X] = req_data.pos_x;
      in_vert[tfc_pkg::FIELD_Y] = req_data.pos_y;
      in_vert[tfc_pkg::FIELD_Z] = req_data.pos_z;
      in_vert[tfc_pkg::FIELD_W] = req_data.pos_w;
      in_vert[tfc_pkg::FIELD_A] = req_data.attr_a;
      in_vert[tfc_pkg::FIELD_B] = req_data.attr_b;
      in_vert[tfc_pkg::FIELD_C] = req_data.attr_c;
      if (cmd.wr_in) begin
         wdata = in_vert;
      end else if (cmd.wr_cross) begin
         wdata = cross_ff;
      end else begin
         wdata = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_in || cmd.wr_cross || cmd.wr_cur) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd) begin
         rd_ff <= mem[raddr];
      end
   end

   assign rd_dist = tfc_pkg::plane_dist(cmd.plane, rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.ld_last) begin
         last_ff <= rd_ff;
         dl_ff   <= rd_dist;
      end else if (cmd.shift_last) begin
         last_ff <= cur_ff;
         dl_ff   <= dc_ff;
      end
      if (cmd.ld_cur) begin
         cur_ff <= rd_ff;
         dc_ff  <= rd_dist;
      end
   end

   // Restoring divider for t = |dL| / (|dL| + |dC|), one quotient bit a cycle.
   assign abs_c = dc_ff[DW-1] ? DW'(-dc_ff) : DW'(dc_ff);
   assign abs_l = dl_ff[DW-1] ? DW'(-dl_ff) : DW'(dl_ff);
   assign den_in     = NW'(abs_c) + NW'(abs_l);
   assign first_ge   = NW'(abs_l) >= den_in;
   assign rem_in     = first_ge ? (NW'(abs_l) - den_in) : NW'(abs_l);
   assign rem_sh     = {rem_ff, 1'b0};
   assign step_ge    = rem_sh >= {1'b0, den_ff};
   assign rem_sh_sub = NW'(rem_sh - {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         den_ff <= den_in;
         rem_ff <= rem_in;
         t_ff   <= TW'(first_ge);
      end else if (cmd.div_step) begin
         rem_ff <= step_ge ? rem_sh_sub : NW'(rem_sh);
         t_ff   <= {t_ff[TW-2:0], step_ge};
      end
   end

   // Interpolation, one field at a time: partial products, then sum and saturate.
   assign diff    = (W+1)'($signed(cur_ff[cmd.fld])) - (W+1)'($signed(last_ff[cmd.fld]));
   assign mag     = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
   assign lo_prod = mag[F-1:0] * t_ff;
   assign prod    = (PW+1)'(phi_ff) + (PW+1)'(plo_ff);
   assign sum     = SW'($signed(last_ff[cmd.fld]))
                  + (neg_ff ? -SW'($signed({1'b0, prod})) : SW'($signed({1'b0, prod})));

   always_comb begin
      if (sum > SW'($signed({1'b0, {(W-1){1'b1}}}))) begin
         sat_val = {1'b0, {(W-1){1'b1}}};
      end else if (sum < SW'($signed({1'b1, {(W-1){1'b0}}}))) begin
         sat_val = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat_val = sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lerp_mul) begin
         phi_ff <= mag[W:F] * t_ff;
         plo_ff <= lo_prod[F+TW-1:F];
         neg_ff <= diff[W];
      end
      if (cmd.lerp_add) begin
         cross_ff[cmd.fld] <= sat_val;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (cmd.rsp_empty) begin
            // Vertex fields zero, last and empty flags set.
            rsp_ff <= {{(7*W){1'b0}}, 1'b1, 1'b1};
         end else begin
            rsp_ff.out_x         <= rd_ff[tfc_pkg::FIELD_X];
            rsp_ff.out_y         <= rd_ff[tfc_pkg::FIELD_Y];
            rsp_ff.out_z         <= rd_ff[tfc_pkg::FIELD_Z];
            rsp_ff.out_w         <= rd_ff[tfc_pkg::FIELD_W];
            rsp_ff.out_attr_a    <= rd_ff[tfc_pkg::FIELD_A];
            rsp_ff.out_attr_b    <= rd_ff[tfc_pkg::FIELD_B];
            rsp_ff.out_attr_c    <= rd_ff[tfc_pkg::FIELD_C];
            rsp_ff.last_vertex   <= cmd.rsp_last;
            rsp_ff.empty_polygon <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign sts.inside_cur   = !dc_ff[DW-1];
   assign sts.inside_last  = !dl_ff[DW-1];
   assign sts.rsp_free     = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== rtl/core/tfc_ctrl.sv =====
// Sequencer of the clipper: walks planes and vertices and drives the datapath.
`include "triangle_frustum_clipper_macros.svh"
module tfc_ctrl #(
   parameter int MAX_POLY_VERTS = 9,
   parameter int AW = 5,
   parameter int CW = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfc_pkg::sts_type sts,
   output tfc_pkg::cmd_type cmd,
   output logic [AW-1:0]    raddr,
   output logic [AW-1:0]    waddr
);

   localparam int DCW = $clog2(tfc_pkg::FRAC_BITS);
   localparam logic [DCW-1:0] DIV_LAST = DCW'(tfc_pkg::FRAC_BITS - 1);
   localparam logic [CW-1:0]  CNT_MAX  = CW'(MAX_POLY_VERTS);
   localparam logic [AW-1:0]  BANK1    = AW'(MAX_POLY_VERTS);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PSTART  = 4'd1;
   localparam logic [3:0] S_PPRIME  = 4'd2;
   localparam logic [3:0] S_VRD     = 4'd3;
   localparam logic [3:0] S_VLD     = 4'd4;
   localparam logic [3:0] S_VDEC    = 4'd5;
   localparam logic [3:0] S_DIV     = 4'd6;
   localparam logic [3:0] S_LMUL    = 4'd7;
   localparam logic [3:0] S_LADD    = 4'd8;
   localparam logic [3:0] S_XWR     = 4'd9;
   localparam logic [3:0] S_VCOPY   = 4'd10;
   localparam logic [3:0] S_OSTART  = 4'd11;
   localparam logic [3:0] S_OEMPTY  = 4'd12;
   localparam logic [3:0] S_ORD     = 4'd13;
   localparam logic [3:0] S_OWR     = 4'd14;

   logic [3:0]     state_ff, state_in;
   logic [1:0]     phase_ff, phase_in;
   logic [2:0]     plane_ff, plane_in;
   logic [2:0]     fld_ff, fld_in;
   logic [DCW-1:0] div_ff, div_in;
   logic [CW-1:0]  n_ff, n_in, cnt_ff, cnt_in, j_ff, j_in;
   logic           src_ff, src_in;
   logic [AW-1:0]  src_base, dst_base;
   logic           take, do_copy;

   assign src_base = src_ff ? BANK1 : '0;
   assign dst_base = src_ff ? '0 : BANK1;
   assign take     = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign do_copy  = sts.inside_cur && (cnt_ff < CNT_MAX);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      plane_in = plane_ff;
      fld_in   = fld_ff;
      div_in   = div_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      src_in   = src_ff;
      cmd      = '0;
      cmd.plane = plane_ff;
      cmd.fld   = fld_ff;
      raddr    = src_base + AW'(j_ff);
      waddr    = dst_base + AW'(cnt_ff);
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.wr_in = 1'b1;
               waddr     = AW'(phase_ff);
               if (phase_ff == 2'd2) begin
                  phase_in = 2'd0;
                  plane_in = tfc_pkg::PLANE_NEAR;
                  n_in     = CW'(3);
                  src_in   = 1'b0;
                  state_in = S_PSTART;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         S_PSTART: begin
            if (plane_ff == tfc_pkg::PLANE_COUNT || n_ff == '0) begin
               state_in = S_OSTART;
            end else begin
               cmd.rd   = 1'b1;
               raddr    = src_base + AW'(n_ff - CW'(1));
               state_in = S_PPRIME;
            end
         end
         S_PPRIME: begin
            cmd.ld_last = 1'b1;
            j_in        = '0;
            cnt_in      = '0;
            state_in    = S_VRD;
         end
         S_VRD: begin
            cmd.rd   = 1'b1;
            state_in = S_VLD;
         end
         S_VLD: begin
            cmd.ld_cur = 1'b1;
            state_in   = S_VDEC;
         end
         S_VDEC: begin
            if ((sts.inside_cur != sts.inside_last) && (cnt_ff < CNT_MAX)) begin
               cmd.div_start = 1'b1;
               div_in        = '0;
               state_in      = S_DIV;
            end else begin
               state_in = S_VCOPY;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_in       = div_ff + DCW'(1);
            if (div_ff == DIV_LAST) begin
               fld_in   = tfc_pkg::FIELD_X;
               state_in = S_LMUL;
            end
         end
         S_LMUL: begin
            cmd.lerp_mul = 1'b1;
            state_in     = S_LADD;
         end
         S_LADD: begin
            cmd.lerp_add = 1'b1;
            if (fld_ff == tfc_pkg::FIELD_C) begin
               state_in = S_XWR;
            end else begin
               fld_in   = fld_ff + 3'd1;
               state_in = S_LMUL;
            end
         end
         S_XWR: begin
            cmd.wr_cross = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            state_in     = S_VCOPY;
         end
         S_VCOPY: begin
            cmd.shift_last = 1'b1;
            if (do_copy) begin
               cmd.wr_cur = 1'b1;
               cnt_in     = cnt_ff + CW'(1);
            end
            j_in = j_ff + CW'(1);
            if (j_ff + CW'(1) == n_ff) begin
               src_in   = !src_ff;
               n_in     = cnt_ff + CW'(do_copy);
               plane_in = plane_ff + 3'd1;
               state_in = S_PSTART;
            end else begin
               state_in = S_VRD;
            end
         end
         S_OSTART: begin
            j_in     = '0;
            state_in = (n_ff == '0) ? S_OEMPTY : S_ORD;
         end
         S_OEMPTY: begin
            if (sts.rsp_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_empty = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ORD: begin
            cmd.rd   = 1'b1;
            state_in = S_OWR;
         end
         S_OWR: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = (j_ff + CW'(1) == n_ff);
               j_in         = j_ff + CW'(1);
               state_in     = (j_ff + CW'(1) == n_ff) ? S_IDLE : S_ORD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
         plane_ff <= tfc_pkg::PLANE_NEAR;
         fld_ff   <= tfc_pkg::FIELD_X;
         div_ff   <= '0;
         n_ff     <= '0;
         cnt_ff   <= '0;
         j_ff     <= '0;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         plane_ff <= plane_in;
         fld_ff   <= fld_in;
         div_ff   <= div_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
         j_ff     <= j_in;
         src_ff   <= src_in;
      end
   end

   `TFC_CHECK(a_cnt_bound, 1'b1, cnt_ff <= CNT_MAX, "polygon count above bank size")
   `TFC_CHECK(a_cross_room, state_ff == S_XWR, cnt_ff < CNT_MAX, "crossing written to full bank")
   `TFC_CHECK(a_rsp_room, cmd.rsp_load, sts.rsp_free, "result loaded over pending word")
   `TFC_CHECK_NEXT(a_tri_start, take && phase_ff == 2'd2,
      state_ff == S_PSTART && plane_ff == tfc_pkg::PLANE_NEAR && n_ff == CW'(3),
      "third vertex did not start clipping")

endmodule
